// ===== src/lwe_decrypt_defines.svh =====
// assertion macros for the lwe_decrypt checker
// clocked on clk, disabled while rst_n is low
`ifndef LWE_DECRYPT_DEFINES_SVH
`define LWE_DECRYPT_DEFINES_SVH

// same-cycle implication
`define LWE_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LWE_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lwe_pkg.sv =====
// shared constants, codes and control structs for lwe_decrypt
// no dependencies
package lwe_pkg;

  localparam int KEY_LENGTH_DEF = 512;
  localparam int KEY_CMP_W      = 13;
  localparam int ACTION_W       = 2;
  localparam int POS_W          = 9;
  localparam int DATA_W         = 32;
  localparam int PMOD_W         = 16;
  localparam int PT_W           = 16;
  localparam int IN_TDATA_W     = 48;
  localparam int OUT_TDATA_W    = 16;
  localparam int DIV_W          = 65;
  localparam int STEP_W         = 7;

  localparam logic [DATA_W-1:0] CMOD_RST = 32'd1024;
  localparam logic [PMOD_W-1:0] PMOD_RST = 16'd4;

  localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MASK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_BODY = 2'd2;

  localparam logic CFG_CMOD = 1'b0;
  localparam logic CFG_PMOD = 1'b1;

  localparam logic [STEP_W-1:0] STEPS_MAC  = 7'd65;
  localparam logic [STEP_W-1:0] STEPS_ACC  = 7'd32;
  localparam logic [STEP_W-1:0] STEPS_OFF  = 7'd32;
  localparam logic [STEP_W-1:0] STEPS_BODY = 7'd35;
  localparam logic [STEP_W-1:0] STEPS_FIN  = 7'd48;

  typedef enum logic [2:0] {
    DIV_MAC,
    DIV_ACC,
    DIV_OFF,
    DIV_BODY,
    DIV_FIN
  } div_sel_t;

  typedef struct packed {
    logic     val_ld;
    logic     key_wr;
    logic     key_rd;
    logic     mul_ld;
    logic     mul_fin;
    logic     div_start;
    div_sel_t div_sel;
    logic     acc_ld;
    logic     acc_clr;
    logic     accr_ld;
    logic     off_ld;
    logic     off_clr;
    logic     res_ld;
    logic     res_zero;
  } lwe_cmd_t;

  typedef struct packed {
    logic pos_ok;
    logic q_ok;
    logic p_nz;
    logic div_busy;
  } lwe_stat_t;

endpackage

// ===== src/lwe_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module lwe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/lwe_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on lwe_pkg
module lwe_div
  import lwe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DATA_W-1:0] divisor,
  input  logic [STEP_W-1:0] steps,
  output logic              busy,
  output logic [DATA_W-1:0] quot,
  output logic [DATA_W-1:0] rem
);

  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (start) begin
      cnt_nxt = steps;
      dvd_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      dvd_nxt = {dvd_r[DIV_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quot = dvd_r[DATA_W-1:0];
  assign rem  = rem_r;

endmodule

// ===== src/lwe_dp.sv =====
// datapath: moduli, key store, multiplier, accumulator and result register
// depends on lwe_pkg, lwe_ram, lwe_div
module lwe_dp
  import lwe_pkg::*;
#(
  parameter int KEY_LENGTH = KEY_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata,
  input  logic [POS_W-1:0]  in_position,
  input  logic [DATA_W-1:0] in_value,
  input  lwe_cmd_t          cmd,
  output lwe_stat_t         stat,
  output logic [PT_W-1:0]   plaintext
);

  localparam int AW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;

  logic [DATA_W-1:0]   q_r;
  logic [PMOD_W-1:0]   p_r;
  logic [DATA_W-1:0]   acc_r;
  logic [DATA_W-1:0]   val_r;
  logic [DATA_W-1:0]   accr_r;
  logic [DATA_W-1:0]   off_r;
  logic [2*DATA_W-1:0] prod_r;
  logic [PT_W-1:0]     res_r;

  logic [KEY_CMP_W-1:0] pos_ext;
  logic [AW-1:0]        key_addr;
  logic [DATA_W-1:0]    key_rdata;
  logic [DIV_W-1:0]     dividend;
  logic [DATA_W-1:0]    divisor;
  logic [STEP_W-1:0]    steps;
  logic [DATA_W-1:0]    div_quot;
  logic [DATA_W-1:0]    div_rem;
  logic                 div_busy;
  logic [DATA_W+2:0]    body_sum;
  logic [DIV_W-1:0]     mac_sum;
  logic [DATA_W+PMOD_W-1:0] fin_prod;

  assign pos_ext  = {{(KEY_CMP_W-POS_W){1'b0}}, in_position};
  assign key_addr = pos_ext[AW-1:0];

  lwe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(KEY_LENGTH),
    .AW   (AW)
  ) u_key_ram (
    .clk    (clk),
    .wr_en  (cmd.key_wr),
    .wr_addr(key_addr),
    .wr_data(in_value),
    .rd_en  (cmd.key_rd),
    .rd_addr(key_addr),
    .rd_data(key_rdata)
  );

  assign mac_sum  = {1'b0, prod_r} + {{(DIV_W-DATA_W){1'b0}}, acc_r};
  assign body_sum = {3'b0, val_r} + {3'b0, q_r} - {3'b0, accr_r} + {3'b0, off_r};
  assign fin_prod = p_r * div_rem;

  always_comb begin
    divisor = q_r;
    unique case (cmd.div_sel)
      DIV_MAC: begin
        dividend = mac_sum;
        steps    = STEPS_MAC;
      end
      DIV_ACC: begin
        dividend = {acc_r, {(DIV_W-DATA_W){1'b0}}};
        steps    = STEPS_ACC;
      end
      DIV_OFF: begin
        dividend = {q_r, {(DIV_W-DATA_W){1'b0}}};
        divisor  = {{(DATA_W-PMOD_W-1){1'b0}}, p_r, 1'b0};
        steps    = STEPS_OFF;
      end
      DIV_BODY: begin
        dividend = {body_sum, {(DIV_W-DATA_W-3){1'b0}}};
        steps    = STEPS_BODY;
      end
      DIV_FIN: begin
        dividend = {fin_prod, {(DIV_W-DATA_W-PMOD_W){1'b0}}};
        steps    = STEPS_FIN;
      end
      default: begin
        dividend = mac_sum;
        steps    = STEPS_MAC;
      end
    endcase
  end

  lwe_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(dividend),
    .divisor (divisor),
    .steps   (steps),
    .busy    (div_busy),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= CMOD_RST;
      p_r   <= PMOD_RST;
      acc_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_CMOD: q_r <= cfg_wdata;
          CFG_PMOD: p_r <= cfg_wdata[PMOD_W-1:0];
        endcase
      end
      if (cmd.acc_clr) begin
        acc_r <= '0;
      end else if (cmd.acc_ld) begin
        acc_r <= div_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.val_ld) begin
      val_r <= in_value;
    end
    if (cmd.mul_ld) begin
      prod_r <= cmd.mul_fin ? {{(DATA_W-PMOD_W){1'b0}}, fin_prod} : val_r * key_rdata;
    end
    if (cmd.accr_ld) begin
      accr_r <= div_rem;
    end
    if (cmd.off_clr) begin
      off_r <= '0;
    end else if (cmd.off_ld) begin
      off_r <= div_quot;
    end
    if (cmd.res_ld) begin
      res_r <= cmd.res_zero ? '0 : div_quot[PT_W-1:0];
    end
  end

  assign stat.pos_ok   = (pos_ext < KEY_CMP_W'(KEY_LENGTH));
  assign stat.q_ok     = |q_r[DATA_W-1:1];
  assign stat.p_nz     = |p_r;
  assign stat.div_busy = div_busy;
  assign plaintext     = res_r;

endmodule

// ===== src/lwe_ctrl.sv =====
// controller: sequences key loads, mask accumulation and the body steps
// depends on lwe_pkg
module lwe_ctrl
  import lwe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [ACTION_W-1:0] in_action,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  lwe_stat_t           stat,
  output lwe_cmd_t            cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_KEY   = 13'b0000000000010,
    S_MAC   = 13'b0000000000100,
    S_MACW  = 13'b0000000001000,
    S_BACC  = 13'b0000000010000,
    S_BACCW = 13'b0000000100000,
    S_BOFF  = 13'b0000001000000,
    S_BOFFW = 13'b0000010000000,
    S_BSUM  = 13'b0000100000000,
    S_BSUMW = 13'b0001000000000,
    S_BFIN  = 13'b0010000000000,
    S_BFINW = 13'b0100000000000,
    S_BOUT  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.val_ld = 1'b1;
          priority if (in_action == ACT_LOAD) begin
            cmd.key_wr = stat.pos_ok;
          end else if (in_action == ACT_MASK) begin
            if (stat.pos_ok && stat.q_ok) begin
              cmd.key_rd = 1'b1;
              state_nxt  = S_KEY;
            end
          end else if (in_action == ACT_BODY) begin
            state_nxt = stat.q_ok ? S_BACC : S_BOUT;
          end
        end
      end
      S_KEY: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = S_MAC;
      end
      S_MAC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MAC;
        state_nxt     = S_MACW;
      end
      S_MACW: begin
        if (!stat.div_busy) begin
          cmd.acc_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_BACC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ACC;
        state_nxt     = S_BACCW;
      end
      S_BACCW: begin
        if (!stat.div_busy) begin
          cmd.accr_ld = 1'b1;
          cmd.off_clr = !stat.p_nz;
          state_nxt   = stat.p_nz ? S_BOFF : S_BSUM;
        end
      end
      S_BOFF: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_OFF;
        state_nxt     = S_BOFFW;
      end
      S_BOFFW: begin
        if (!stat.div_busy) begin
          cmd.off_ld = 1'b1;
          state_nxt  = S_BSUM;
        end
      end
      S_BSUM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_BODY;
        state_nxt     = S_BSUMW;
      end
      S_BSUMW: begin
        if (!stat.div_busy) begin
          cmd.mul_ld  = 1'b1;
          cmd.mul_fin = 1'b1;
          state_nxt   = S_BFIN;
        end
      end
      S_BFIN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FIN;
        state_nxt     = S_BFINW;
      end
      S_BFINW: begin
        if (!stat.div_busy) begin
          state_nxt = S_BOUT;
        end
      end
      S_BOUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.res_ld   = 1'b1;
          cmd.res_zero = !stat.q_ok;
          cmd.acc_clr  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ===== src/lwe_decrypt.sv =====
// lwe_decrypt: LWE decryption with a key store and a serial modular unit
// Input channel in_*: in_tuser carries the action, in_tdata the position and value.
//   A key-load item writes the key store.
//   A mask item adds a*s mod q to the accumulator.
//   A body item yields one plaintext item; the offset step is skipped when the
//   plaintext modulus is zero, and the plaintext is zero when q is below 2.
//   Items are worked one at a time; in_tready is high only between items.
//   The modular work is done by the bit-serial divider, one quotient bit a cycle:
//   65 steps for a mask item, up to 32 + 32 + 35 + 48 steps for a body item.
// Output channel out_*: one plaintext item per body item, held in an output
//   register; a new item is accepted while it waits, and the block stalls in
//   its last step only if a second result is ready before the first is taken.
// Configuration: cfg_wr_en, cfg_index, cfg_wdata write q (index 0) or p (index 1);
//   the user must write them only while the block is idle; the block does not enforce it.
// Reset (rst_n low, synchronous): q = 1024, p = 4, accumulator cleared,
//   output empty; the key store keeps no reset value and must be loaded.
// depends on lwe_pkg, lwe_ctrl, lwe_dp
module lwe_decrypt
  import lwe_pkg::*;
#(
  parameter int KEY_LENGTH = KEY_LENGTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position [8:0], value [40:9], zero pad
  input  logic [ACTION_W-1:0]    in_tuser,   // action [1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // plaintext [15:0]
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [DATA_W-1:0]      cfg_wdata
);

  lwe_cmd_t  cmd;
  lwe_stat_t stat;

  lwe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lwe_dp #(
    .KEY_LENGTH(KEY_LENGTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_position(in_tdata[POS_W-1:0]),
    .in_value   (in_tdata[POS_W+DATA_W-1:POS_W]),
    .cmd        (cmd),
    .stat       (stat),
    .plaintext  (out_tdata)
  );

endmodule

// ===== src/lwe_chk.sv =====
// port-level checker for lwe_decrypt, bound to the top level
// depends on lwe_pkg and lwe_decrypt_defines.svh
`include "lwe_decrypt_defines.svh"

module lwe_chk
  import lwe_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [ACTION_W-1:0]    in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `LWE_AST_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "output item changed while stalled")

  `LWE_AST_NXT(a_body_busy, in_tvalid && in_tready && (in_tuser == ACT_BODY),
    !in_tready, "body item did not start the finish sequence")

  `LWE_AST_NXT(a_load_idle, in_tvalid && in_tready && (in_tuser == ACT_LOAD),
    in_tready, "key load did not complete in one cycle")

  `LWE_AST_NOW(a_out_src, $rose(out_tvalid), $past(!in_tready),
    "output item appeared outside a body sequence")

endmodule

bind lwe_decrypt lwe_chk u_chk (.*);

// ===== tb/lwe_decrypt_check.sv =====
`timescale 1ns / 100ps
// lwe_decrypt_check: watches the key, ciphertext and plaintext streams of lwe_decrypt,
// predicts every plaintext item from its own key store and moduli and compares them
// depends on lwe_pkg
module lwe_decrypt_check
  import lwe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position [8:0], value [40:9], zero pad
  input  logic [ACTION_W-1:0]    in_tuser,   // action [1:0]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // plaintext [15:0]
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [DATA_W-1:0]      cfg_wdata,
  output int                     fail_count,
  output int                     pending,
  output int                     checked
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } cipher_item_t;

  logic [DATA_W-1:0] key_mem [KEY_LENGTH_DEF];
  logic [DATA_W-1:0] acc_sum;
  logic [DATA_W-1:0] cmod;
  logic [PMOD_W-1:0] pmod;
  logic [PT_W-1:0]   plaintext_due [$];

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic decrypt_step(input logic [ACTION_W-1:0] act, input cipher_item_t item);
    longint unsigned q, p, b, a, r, prod, offset;
    q = cmod;
    p = pmod;
    case (act)
      ACT_LOAD: key_mem[item.position] = item.value;
      ACT_MASK: begin
        if (q >= 2) begin
          prod = ((item.value % q) * (key_mem[item.position] % q)) % q;
          acc_sum = DATA_W'(((acc_sum % q) + prod) % q);
        end
      end
      ACT_BODY: begin
        r = 0;
        if (q >= 2) begin
          b = item.value % q;
          a = acc_sum % q;
          r = (b >= a) ? (b - a) : (b + q - a);
          offset = (p != 0) ? q / (p * 2) : 0;
          r = (r + offset) % q;
          r = (p * r) / q;
        end
        plaintext_due.push_back(PT_W'(r));
        acc_sum = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_plaintext(input logic [PT_W-1:0] got);
    logic [PT_W-1:0] want;
    checked++;
    if (plaintext_due.size() == 0) begin
      report_mismatch($sformatf("plaintext %0d with no item pending", got));
    end else begin
      want = plaintext_due.pop_front();
      if (got !== want)
        report_mismatch($sformatf("plaintext %0d, expected %0d", got, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cmod = CMOD_RST;
      pmod = PMOD_RST;
      acc_sum = '0;
      plaintext_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_CMOD) cmod = cfg_wdata;
        else pmod = cfg_wdata[PMOD_W-1:0];
      end
      if (out_tvalid && out_tready) check_plaintext(out_tdata[PT_W-1:0]);
      if (in_tvalid && in_tready) decrypt_step(in_tuser, in_tdata[POS_W+DATA_W-1:0]);
    end
    pending = plaintext_due.size();
  end

endmodule

// ===== tb/lwe_decrypt_test.sv =====
`timescale 1ns / 100ps
// lwe_decrypt_test: drives key loads, ciphertexts and modulus settings into lwe_decrypt
// with random gaps and stalls; lwe_decrypt_check predicts and compares the plaintext
// depends on lwe_pkg, lwe_decrypt, lwe_decrypt_check
module lwe_decrypt_test;
  import lwe_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int ITEM_GOAL     = 550;
  localparam int SETTLE_CYCLES = 200;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [ACTION_W-1:0]    in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [DATA_W-1:0]      cfg_wdata = '0;

  int fail_count;
  int pending;
  int checked;

  logic [DATA_W-1:0] cur_q = CMOD_RST;
  logic [PMOD_W-1:0] cur_p = PMOD_RST;
  bit                key_loaded [KEY_LENGTH_DEF];
  int                loaded_list [$];
  int                items_sent = 0;
  int                ciphers_sent = 0;
  int                settings_used = 0;
  bit                tx_steady = 1'b0;
  bit                rx_steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lwe_decrypt dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  lwe_decrypt_check checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // plaintext receiver
  initial begin
    int stall;
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready && rst_n));
    end
  end

  task automatic send(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                      input logic [DATA_W-1:0] val);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {{(IN_TDATA_W-POS_W-DATA_W){1'b0}}, val, pos};
    do @(posedge clk); while (!in_tready);
    if (act != ACT_NONE) items_sent++;
    if (act == ACT_LOAD && !key_loaded[pos]) begin
      key_loaded[pos] = 1'b1;
      loaded_list.push_back(int'(pos));
    end
  endtask

  // wait for every pending plaintext, then let a mask item still in flight finish
  task automatic settle;
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_CMOD) cur_q = v;
    else cur_p = v[PMOD_W-1:0];
  endtask

  task automatic set_moduli(input logic [DATA_W-1:0] q, input logic [PMOD_W-1:0] p);
    settle;
    write_reg(CFG_CMOD, q);
    write_reg(CFG_PMOD, {{(DATA_W-PMOD_W){1'b0}}, p});
    settings_used++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value;
    int sel;
    sel = $urandom_range(0, 19);
    if (cur_q < 2 || sel < 2) return $urandom;
    if (sel == 2) return cur_q - 1;
    return $urandom_range(0, cur_q - 1);
  endfunction

  function automatic logic [POS_W-1:0] pick_loaded;
    return POS_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  function automatic logic [DATA_W-1:0] pick_q;
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'd2;
      2: return $urandom_range(2, 32'hFFFF_FFFF);
      3: return $urandom_range(2, 4096);
      4: return 32'd1 << $urandom_range(1, 31);
      default: return $urandom_range(3, 1000);
    endcase
  endfunction

  function automatic logic [PMOD_W-1:0] pick_p;
    case ($urandom_range(0, 4))
      0: return 16'hFFFF;
      1: return 16'd2;
      2: return PMOD_W'($urandom_range(2, 65535));
      default: return PMOD_W'($urandom_range(2, 16));
    endcase
  endfunction

  task automatic run_cipher(input int n_mask);
    repeat (n_mask) begin
      if ($urandom_range(0, 7) == 0)
        send(ACT_LOAD, POS_W'($urandom_range(0, KEY_LENGTH_DEF - 1)),
             $urandom_range(0, 1) ? pick_value() : $urandom);
      if ($urandom_range(0, 15) == 0) send(ACT_NONE, POS_W'($urandom), $urandom);
      send(ACT_MASK, pick_loaded(), pick_value());
    end
    send(ACT_BODY, POS_W'($urandom), pick_value());
    ciphers_sent++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset moduli, key extremes, mask values just below and above q, unused action
    send(ACT_LOAD, 9'd0, 32'd1023);
    send(ACT_LOAD, 9'd511, 32'hFFFF_FFFF);
    send(ACT_LOAD, 9'd1, 32'd0);
    send(ACT_LOAD, 9'd2, 32'd5);
    send(ACT_MASK, 9'd0, 32'd1023);
    send(ACT_MASK, 9'd511, 32'hFFFF_FFFF);
    send(ACT_MASK, 9'd2, 32'd0);
    send(ACT_NONE, 9'h155, 32'hA5A5_A5A5);
    send(ACT_BODY, 9'd0, 32'd0);
    send(ACT_BODY, 9'd511, 32'd1023);
    send(ACT_BODY, 9'd0, 32'hFFFF_FFFF);

    // widest moduli, then q changed under a live accumulator
    set_moduli(32'hFFFF_FFFF, 16'hFFFF);
    send(ACT_MASK, 9'd511, 32'hFFFF_FFFE);
    send(ACT_MASK, 9'd0, 32'd12345);
    settle;
    write_reg(CFG_CMOD, 32'd1000);
    send(ACT_BODY, 9'd0, 32'd7);

    // degenerate q
    set_moduli(32'd1, 16'd2);
    send(ACT_MASK, 9'd0, 32'd5);
    send(ACT_BODY, 9'd0, 32'd3);
    settle;
    write_reg(CFG_CMOD, 32'd0);
    send(ACT_MASK, 9'd1, 32'd9);
    send(ACT_BODY, 9'd0, 32'd9);

    // zero p, then p above q
    set_moduli(32'd97, 16'd0);
    send(ACT_MASK, 9'd2, 32'd50);
    send(ACT_BODY, 9'd0, 32'd96);
    set_moduli(32'd2, 16'hFFFF);
    send(ACT_MASK, 9'd0, 32'd1);
    send(ACT_BODY, 9'd0, 32'd1);

    while (items_sent < ITEM_GOAL) begin
      set_moduli(pick_q(), pick_p());
      repeat ($urandom_range(2, 6)) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0)
          send(ACT_LOAD, POS_W'($urandom_range(0, KEY_LENGTH_DEF - 1)), $urandom);
        run_cipher($urandom_range(0, 8));
      end
    end

    settle;
    $display("sent %0d items in %0d ciphertexts under %0d modulus settings",
             items_sent, ciphers_sent, settings_used);
    $display("checked %0d plaintext items", checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/lwe_pkg.sv
src/lwe_ram.sv
src/lwe_div.sv
src/lwe_dp.sv
src/lwe_ctrl.sv
src/lwe_decrypt.sv
src/lwe_chk.sv
tb/lwe_decrypt_check.sv
tb/lwe_decrypt_test.sv
